### sv/hgvn_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap vertex normal package
// Shared constants, types and helpers for the heightmap vertex generator.
// ----------------------------------------------------------------------------
package hgvn_pkg;

  // Largest supported grid size in cells per side.
  localparam int GRID_MAX = 32;
  localparam int ROW_LEN = GRID_MAX + 1;
  // The line store keeps four rows in a ring.
  localparam int RING_ROWS = 4;
  localparam int STORE_DEPTH = RING_ROWS * ROW_LEN;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic REG_GRID_SIZE = 1'b0;
  localparam logic REG_CELL_SIZE = 1'b1;

  // One vertex job: a single vertex, or the flush of a whole last row.
  typedef struct packed {
    logic [5:0] x;
    logic [5:0] z;
    logic [1:0] ring;
    logic       flush;
  } job_t;

  // Line store write request from the front end.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
  } store_wr_t;

  // Ring row of the oldest job still in flight.
  typedef struct packed {
    logic       valid;
    logic [1:0] ring;
  } oldest_t;

  // Address of column x in ring row r.
  function automatic logic [ADDR_W-1:0] store_addr(input logic [1:0] r, input logic [5:0] x);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(r) * ADDR_W'(ROW_LEN);
    return base + ADDR_W'(x);
  endfunction

endpackage

### sv/hgvn_front.sv
// ----------------------------------------------------------------------------
// Heightmap vertex front end
// Accepts height samples, writes them to the line store and queues vertex jobs.
// ----------------------------------------------------------------------------
module hgvn_front import hgvn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [5:0]  grid_eff,
  input  logic        grid_wr,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] height,
  output store_wr_t   store_wr,
  input  logic        q_full,
  input  oldest_t     oldest,
  output logic        push,
  output job_t        push_job
);

  logic [5:0] col_count;
  logic [5:0] row_count;
  logic [1:0] ring;
  logic       pend_flush;
  logic [1:0] pend_ring;
  logic [5:0] x;
  logic [5:0] z;
  logic       accept;
  logic       hazard;
  logic       row_end;
  logic       chunk_end;

  // Current sample position, restarting the chunk if counters ran off the grid.
  always_comb begin
    if (col_count > grid_eff || row_count > grid_eff) begin
      x = '0;
      z = '0;
    end else begin
      x = col_count;
      z = row_count;
    end
  end

  // A write must not overwrite a row that the oldest job still reads.
  assign hazard = oldest.valid && ((ring - oldest.ring) == 2'd3);
  assign in_stall = pend_flush || q_full || hazard;
  assign accept = in_valid && !in_stall;
  assign row_end = (x == grid_eff);
  assign chunk_end = row_end && (z == grid_eff);

  // Line store write of the accepted sample.
  always_comb begin
    store_wr.en = accept;
    store_wr.addr = store_addr(ring, x);
    store_wr.data = height;
  end

  // Job push: the vertex one row up, or the pending flush of the last row.
  always_comb begin
    push = 1'b0;
    push_job = '0;
    if (pend_flush) begin
      push = !q_full;
      push_job.x = '0;
      push_job.z = grid_eff;
      push_job.ring = pend_ring;
      push_job.flush = 1'b1;
    end else if (accept && z != '0) begin
      push = 1'b1;
      push_job.x = x;
      push_job.z = z - 6'd1;
      push_job.ring = ring - 2'd1;
      push_job.flush = 1'b0;
    end
  end

  // Sample position counters and the ring row pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      ring <= '0;
      pend_flush <= 1'b0;
      pend_ring <= '0;
    end else if (grid_wr) begin
      col_count <= '0;
      row_count <= '0;
    end else begin
      if (pend_flush && !q_full) begin
        pend_flush <= 1'b0;
      end
      if (accept) begin
        if (chunk_end) begin
          col_count <= '0;
          row_count <= '0;
          ring <= ring + 2'd1;
          pend_flush <= 1'b1;
          pend_ring <= ring;
        end else if (row_end) begin
          col_count <= '0;
          row_count <= z + 6'd1;
          ring <= ring + 2'd1;
        end else begin
          col_count <= x + 6'd1;
          row_count <= z;
        end
      end
    end
  end

endmodule

### sv/hgvn_queue.sv
// ----------------------------------------------------------------------------
// Heightmap vertex job queue
// Short FIFO of vertex jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module hgvn_queue import hgvn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output job_t q_head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_valid = (count != '0);
  assign q_full = (count == CNT_W'(QUEUE_DEPTH));
  assign q_head = entries[rd_ptr];

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/hgvn_back.sv
// ----------------------------------------------------------------------------
// Heightmap vertex back end
// Holds the line store and computes position, UV and normal of each vertex.
// ----------------------------------------------------------------------------
module hgvn_back import hgvn_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [5:0]   grid_eff,
  input  logic [15:0]  cell_eff,
  input  store_wr_t    store_wr,
  input  logic         q_valid,
  input  job_t         q_head,
  output logic         pop,
  output oldest_t      oldest,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [10:0]  vertex_index,
  output logic [20:0]  pos_x,
  output logic [20:0]  pos_z,
  output logic signed [15:0] vertex_height,
  output logic signed [15:0] normal_x,
  output logic [14:0]  normal_y,
  output logic signed [15:0] normal_z,
  output logic [16:0]  tex_u,
  output logic [16:0]  tex_v,
  output logic         last
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_PREP, S_SQ, S_SQRT, S_DIV, S_FIN, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NX, OP_NY, OP_NZ, OP_TU, OP_TV
  } div_op_t;

  state_t  state;
  div_op_t op;
  job_t    job;
  logic [4:0]  cnt;

  logic [15:0] mem [STORE_DEPTH];
  logic [ADDR_W-1:0] rd_addr;
  logic [15:0] rd_data;

  logic signed [15:0] h_c, hr_c, hl_c, hd_c, hu_c;
  logic [16:0] mag_a, mag_b, c_val;
  logic        a_neg, b_neg;
  logic [35:0] acc;
  logic [35:0] sq_sh;
  logic [21:0] sq_rem;
  logic [17:0] root;
  logic [17:0] div_rem;
  logic [16:0] div_lo;
  logic [17:0] div_d;
  logic [16:0] div_q;
  logic [16:0] q_nx, q_ny, q_nz;

  logic [1:0]  up_ring, dn_ring;
  logic [5:0]  xr, xl;
  logic [16:0] sq_op;
  logic [33:0] sq_prod;
  logic [21:0] sq_rs, sq_trial;
  logic        sq_ge;
  logic [18:0] div_rs;
  logic        div_ge;
  logic [31:0] div_num;
  logic [17:0] div_den;
  logic signed [16:0] a_full, b_full;

  // Neighbor positions with clamping at the grid edges.
  always_comb begin
    up_ring = (job.z == '0) ? job.ring : job.ring - 2'd1;
    dn_ring = (job.z >= grid_eff) ? job.ring : job.ring + 2'd1;
    xr = (job.x >= grid_eff) ? grid_eff : job.x + 6'd1;
    xl = (job.x == '0) ? '0 : job.x - 6'd1;
  end

  // Read address sequence: center, right, left, down, up.
  always_comb begin
    case (cnt[2:0])
      3'd0:    rd_addr = store_addr(job.ring, job.x);
      3'd1:    rd_addr = store_addr(job.ring, xr);
      3'd2:    rd_addr = store_addr(job.ring, xl);
      3'd3:    rd_addr = store_addr(dn_ring, job.x);
      default: rd_addr = store_addr(up_ring, job.x);
    endcase
  end

  // Line store: one write port from the front end, one registered read port.
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.addr] <= store_wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  // Central differences.
  assign a_full = 17'(hr_c) - 17'(hl_c);
  assign b_full = 17'(hd_c) - 17'(hu_c);

  // One square per cycle for the length accumulation.
  always_comb begin
    case (cnt[1:0])
      2'd0:    sq_op = mag_a;
      2'd1:    sq_op = mag_b;
      default: sq_op = c_val;
    endcase
    sq_prod = sq_op * sq_op;
  end

  // One root bit per cycle.
  always_comb begin
    sq_rs = {sq_rem[19:0], sq_sh[35:34]};
    sq_trial = {2'b00, root, 2'b01};
    sq_ge = (sq_rs >= sq_trial);
  end

  // Division operands for each operation.
  always_comb begin
    case (op)
      OP_NX: begin
        div_num = {1'b0, mag_a, 14'd0};
        div_den = root;
      end
      OP_NY: begin
        div_num = {1'b0, c_val, 14'd0};
        div_den = root;
      end
      OP_NZ: begin
        div_num = {1'b0, mag_b, 14'd0};
        div_den = root;
      end
      OP_TU: begin
        div_num = {10'd0, job.x, 16'd0};
        div_den = {12'd0, grid_eff};
      end
      default: begin
        div_num = {10'd0, job.z, 16'd0};
        div_den = {12'd0, grid_eff};
      end
    endcase
  end

  // One quotient bit per cycle.
  always_comb begin
    div_rs = {div_rem, div_lo[16]};
    div_ge = (div_rs >= {1'b0, div_d});
  end

  assign pop = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  // Oldest job still needing the line store.
  always_comb begin
    if (state != S_IDLE) begin
      oldest.valid = 1'b1;
      oldest.ring = job.ring;
    end else begin
      oldest.valid = q_valid;
      oldest.ring = q_head.ring;
    end
  end

  // Vertex sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      op <= OP_NX;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job <= q_head;
            cnt <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          case (cnt[2:0])
            3'd1:    h_c <= rd_data;
            3'd2:    hr_c <= rd_data;
            3'd3:    hl_c <= rd_data;
            3'd4:    hd_c <= rd_data;
            3'd5:    hu_c <= rd_data;
            default: ;
          endcase
          if (cnt == 5'd5) begin
            state <= S_PREP;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_PREP: begin
          a_neg <= a_full[16];
          b_neg <= b_full[16];
          mag_a <= a_full[16] ? 17'(-a_full) : 17'(a_full);
          mag_b <= b_full[16] ? 17'(-b_full) : 17'(b_full);
          c_val <= {cell_eff, 1'b0};
          acc <= '0;
          cnt <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          acc <= acc + 36'(sq_prod);
          if (cnt == 5'd2) begin
            cnt <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_SQRT: begin
          if (cnt == '0) begin
            sq_sh <= acc;
            sq_rem <= '0;
            root <= '0;
            cnt <= 5'd1;
          end else begin
            sq_sh <= {sq_sh[33:0], 2'b00};
            if (sq_ge) begin
              sq_rem <= sq_rs - sq_trial;
              root <= {root[16:0], 1'b1};
            end else begin
              sq_rem <= sq_rs;
              root <= {root[16:0], 1'b0};
            end
            if (cnt == 5'd18) begin
              cnt <= '0;
              op <= OP_NX;
              state <= S_DIV;
            end else begin
              cnt <= cnt + 5'd1;
            end
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            div_rem <= {3'd0, div_num[31:17]};
            div_lo <= div_num[16:0];
            div_d <= div_den;
            div_q <= '0;
            cnt <= 5'd1;
          end else if (cnt == 5'd18) begin
            cnt <= '0;
            case (op)
              OP_NX: q_nx <= div_q;
              OP_NY: q_ny <= div_q;
              OP_NZ: q_nz <= div_q;
              OP_TU: tex_u <= div_q;
              default: tex_v <= div_q;
            endcase
            if (op == OP_TV) begin
              state <= S_FIN;
            end else begin
              op <= div_op_t'(op + 3'd1);
            end
          end else begin
            div_rem <= div_ge ? 18'(div_rs - {1'b0, div_d}) : div_rs[17:0];
            div_lo <= {div_lo[15:0], 1'b0};
            div_q <= {div_q[15:0], div_ge};
            cnt <= cnt + 5'd1;
          end
        end
        S_FIN: begin
          vertex_index <= 11'(12'(job.z) * 12'({1'b0, grid_eff} + 7'd1) + 12'(job.x));
          pos_x <= 21'(job.x * cell_eff);
          pos_z <= 21'(job.z * cell_eff);
          vertex_height <= h_c;
          normal_x <= a_neg ? q_nx[15:0] : 16'(-q_nx[15:0]);
          normal_y <= q_ny[14:0];
          normal_z <= b_neg ? q_nz[15:0] : 16'(-q_nz[15:0]);
          last <= job.flush && (job.x == grid_eff);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (job.flush && job.x != grid_eff) begin
              job.x <= job.x + 6'd1;
              cnt <= '0;
              state <= S_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/heightmap_grid_vertex_normals.sv
// ----------------------------------------------------------------------------
// Heightmap grid vertex normals
// Turns a row-major height stream into vertices with position, UV and normal.
// ----------------------------------------------------------------------------
// Heights are taken at up to one request per cycle into a four-row line store
// while a short job queue decouples intake from vertex generation. Each vertex
// is produced by a sequential back end, which takes no new job until the last
// one is output: a queue pop, five store reads, a setup step, three squares, a
// square root (18 steps) and five divisions (17 steps each) sharing one
// divider, a step to assemble the result and an output state that holds while
// the output is stalled. The sustained rate is set by that divider and root
// unit. The last sample of a chunk also produces the whole last row, each
// further vertex of that row starting again at the store reads without a queue
// pop. Intake stalls while the queue is full, while a last-row flush waits to
// be queued, or while a new row would overwrite a row that a pending vertex
// still needs.
module heightmap_grid_vertex_normals import hgvn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] height,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] vertex_index,
  output logic [20:0] pos_x,
  output logic [20:0] pos_z,
  output logic signed [15:0] vertex_height,
  output logic signed [15:0] normal_x,
  output logic [14:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [16:0] tex_u,
  output logic [16:0] tex_v,
  output logic        last
);

  logic [5:0]  grid_size;
  logic [15:0] cell_size;
  logic [5:0]  grid_eff;
  logic [15:0] cell_eff;
  logic        grid_wr;
  store_wr_t   store_wr;
  oldest_t     oldest;
  logic        push, pop, q_valid, q_full;
  job_t        push_job, q_head;

  assign cfg_ready = 1'b1;
  assign grid_wr = cfg_valid && (cfg_index == REG_GRID_SIZE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= 6'd16;
      cell_size <= 16'd256;
    end else if (cfg_valid) begin
      if (cfg_index == REG_GRID_SIZE) begin
        grid_size <= cfg_data[5:0];
      end else if (cfg_index == REG_CELL_SIZE) begin
        cell_size <= cfg_data;
      end
    end
  end

  // Effective grid and cell sizes.
  always_comb begin
    if (grid_size == '0) begin
      grid_eff = 6'd1;
    end else if (grid_size > 6'(GRID_MAX)) begin
      grid_eff = 6'(GRID_MAX);
    end else begin
      grid_eff = grid_size;
    end
    cell_eff = (cell_size == '0) ? 16'd1 : cell_size;
  end

  hgvn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .grid_eff (grid_eff),
    .grid_wr  (grid_wr),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .height   (height),
    .store_wr (store_wr),
    .q_full   (q_full),
    .oldest   (oldest),
    .push     (push),
    .push_job (push_job)
  );

  hgvn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_head   (q_head)
  );

  hgvn_back u_back (
    .clk           (clk),
    .rst           (rst),
    .grid_eff      (grid_eff),
    .cell_eff      (cell_eff),
    .store_wr      (store_wr),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .pop           (pop),
    .oldest        (oldest),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .vertex_index  (vertex_index),
    .pos_x         (pos_x),
    .pos_z         (pos_z),
    .vertex_height (vertex_height),
    .normal_x      (normal_x),
    .normal_y      (normal_y),
    .normal_z      (normal_z),
    .tex_u         (tex_u),
    .tex_v         (tex_v),
    .last          (last)
  );

endmodule
